@@ sv/pps_pkg.sv @@
// Package for the preemptive priority scheduler: sizes, result and operation codes,
// and the microcode program with its control word layout.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package pps_pkg;

	localparam int PPS_READY_DEPTH = 16;
	localparam int PPS_TIME_BITS   = 16;
	localparam int KEY_W           = 16;   // priority in the upper byte, job id below

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [1:0] K_SEGMENT  = 2'd0;
	localparam logic [1:0] K_COMPLETE = 2'd1;
	localparam logic [1:0] K_IDLE     = 2'd2;
	localparam logic [1:0] K_OVERFLOW = 2'd3;

	typedef logic [2:0] act_t;
	typedef logic [2:0] cond_t;
	typedef logic [2:0] step_t;

	// Datapath actions.
	localparam act_t A_WAIT     = 3'd0;
	localparam act_t A_SCAN     = 3'd1;
	localparam act_t A_FETCH    = 3'd2;
	localparam act_t A_ARRIVE   = 3'd3;
	localparam act_t A_COMPLETE = 3'd4;
	localparam act_t A_DISPATCH = 3'd5;
	localparam act_t A_ADVANCE  = 3'd6;
	localparam act_t A_NOP      = 3'd7;

	// Jump conditions; when the condition is false the program falls through.
	localparam cond_t C_NEVER     = 3'd0;
	localparam cond_t C_ALWAYS    = 3'd1;
	localparam cond_t C_NO_START  = 3'd2;
	localparam cond_t C_SCAN_MORE = 3'd3;
	localparam cond_t C_TICK      = 3'd4;

	// Program addresses.
	localparam step_t ST_WAIT     = 3'd0;
	localparam step_t ST_SCAN     = 3'd1;
	localparam step_t ST_FETCH    = 3'd2;
	localparam step_t ST_ARRIVE   = 3'd3;
	localparam step_t ST_COMPLETE = 3'd4;
	localparam step_t ST_DISPATCH = 3'd5;
	localparam step_t ST_ADVANCE  = 3'd6;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic start;
		logic scan_more;
		logic tick;
	} seq_flags_t;

	function automatic uword_t ucode(input step_t pc);
		uword_t w;
		case (pc)
			ST_WAIT:     w = '{A_WAIT,     C_NO_START,  ST_WAIT};
			ST_SCAN:     w = '{A_SCAN,     C_SCAN_MORE, ST_SCAN};
			ST_FETCH:    w = '{A_FETCH,    C_TICK,      ST_COMPLETE};
			ST_ARRIVE:   w = '{A_ARRIVE,   C_ALWAYS,    ST_WAIT};
			ST_COMPLETE: w = '{A_COMPLETE, C_NEVER,     ST_WAIT};
			ST_DISPATCH: w = '{A_DISPATCH, C_NEVER,     ST_WAIT};
			ST_ADVANCE:  w = '{A_ADVANCE,  C_ALWAYS,    ST_WAIT};
			default:     w = '{A_NOP,      C_ALWAYS,    ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

@@ sv/pps_sequencer.sv @@
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on pps_pkg for the control word layout and the program.
`timescale 1ns / 1ps

module pps_sequencer import pps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  seq_flags_t flags,
	output act_t       act,
	output logic       busy
);

	step_t  pc_q;
	uword_t word;
	logic   take;

	assign word = ucode(pc_q);
	assign act  = word.act;
	assign busy = (pc_q != ST_WAIT);

	always_comb begin
		case (word.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_START:  take = !flags.start;
			C_SCAN_MORE: take = flags.scan_more;
			C_TICK:      take = flags.tick;
			default:     take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_WAIT;
		end else if (take) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + step_t'(1);
		end
	end

endmodule

@@ sv/pps_ready_table.sv @@
// Ready table: valid flags, key and time memories, and the scan that finds the lowest
// free entry and the most urgent ready entry, one entry per cycle.
// Depends on pps_pkg for action codes and the key width.
`timescale 1ns / 1ps

module pps_ready_table import pps_pkg::*; #(
	parameter int READY_DEPTH = PPS_READY_DEPTH,
	parameter int TIME_BITS   = PPS_TIME_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  act_t                   act,
	input  logic                   wr_en,
	input  logic [KEY_W-1:0]       wr_key,
	input  logic [3*TIME_BITS-1:0] wr_times,
	input  logic                   clr_en,
	output logic                   scan_more,
	output logic                   free_found,
	output logic                   best_found,
	output logic [KEY_W-1:0]       best_key,
	output logic [3*TIME_BITS-1:0] best_times
);

	localparam int IW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
	localparam int CW = $clog2(READY_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(READY_DEPTH);

	logic [KEY_W-1:0]       key_mem [READY_DEPTH];
	logic [3*TIME_BITS-1:0] times_mem [READY_DEPTH];
	logic [READY_DEPTH-1:0] valid_q;

	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          prev_cnt;
	logic [IW-1:0]          eval_idx;
	logic [KEY_W-1:0]       key_rd_q;
	logic [3*TIME_BITS-1:0] times_rd_q;
	logic                   free_found_q;
	logic                   best_found_q;
	logic [IW-1:0]          free_idx_q;
	logic [IW-1:0]          best_idx_q;
	logic [KEY_W-1:0]       best_key_q;
	logic                   evaluating;
	logic                   take_free;
	logic                   take_best;

	// The key read issued at count c is registered and judged as entry c once the count is c+1.
	assign prev_cnt   = cnt_q - CW'(1);
	assign eval_idx   = prev_cnt[IW-1:0];
	assign scan_more  = (cnt_q != DEPTH_C);
	assign evaluating = (act == A_SCAN) && (cnt_q != '0);
	assign take_free  = evaluating && !valid_q[eval_idx] && !free_found_q;
	assign take_best  = evaluating && valid_q[eval_idx]
	                    && (!best_found_q || (key_rd_q < best_key_q));

	assign free_found = free_found_q;
	assign best_found = best_found_q;
	assign best_key   = best_key_q;
	assign best_times = times_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			valid_q      <= '0;
		end else begin
			if (act == A_WAIT) begin
				cnt_q        <= '0;
				free_found_q <= 1'b0;
				best_found_q <= 1'b0;
			end else if (act == A_SCAN) begin
				if (scan_more) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (take_free) begin
					free_found_q <= 1'b1;
				end
				if (take_best) begin
					best_found_q <= 1'b1;
				end
			end
			if (wr_en) begin
				valid_q[free_idx_q] <= 1'b1;
			end else if (clr_en) begin
				valid_q[best_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_free) begin
			free_idx_q <= eval_idx;
		end
		if (take_best) begin
			best_idx_q <= eval_idx;
			best_key_q <= key_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (act == A_SCAN && scan_more) begin
			key_rd_q <= key_mem[cnt_q[IW-1:0]];
		end
		if (wr_en) begin
			key_mem[free_idx_q] <= wr_key;
		end
	end

	always_ff @(posedge clk) begin
		if (act == A_FETCH) begin
			times_rd_q <= times_mem[best_idx_q];
		end
		if (wr_en) begin
			times_mem[free_idx_q] <= wr_times;
		end
	end

endmodule

@@ sv/pps_job_unit.sv @@
// Job unit: command latch, clock, running job registers, preemption and completion
// arithmetic, and the registered result outputs.
// Depends on pps_pkg for action, operation and result codes.
`timescale 1ns / 1ps

module pps_job_unit import pps_pkg::*; #(
	parameter int TIME_BITS = PPS_TIME_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  act_t                   act,
	input  logic                   start,
	input  logic                   operation,
	input  logic [7:0]             job_id,
	input  logic [7:0]             job_priority,
	input  logic [15:0]            job_burst,
	input  logic                   free_found,
	input  logic                   best_found,
	input  logic [KEY_W-1:0]       best_key,
	input  logic [3*TIME_BITS-1:0] best_times,
	output logic                   op_tick,
	output logic                   wr_en,
	output logic [KEY_W-1:0]       wr_key,
	output logic [3*TIME_BITS-1:0] wr_times,
	output logic                   clr_en,
	output logic                   done,
	output logic [1:0]             kind,
	output logic [7:0]             out_job,
	output logic [15:0]            segment_start,
	output logic [15:0]            event_time,
	output logic [15:0]            turnaround,
	output logic [15:0]            waiting,
	output logic                   last
);

	localparam int TW = TIME_BITS;

	logic          op_q;
	logic [7:0]    id_q;
	logic [7:0]    pri_q;
	logic [TW-1:0] burst_q;

	logic             run_valid_q;
	logic [KEY_W-1:0] run_key_q;
	logic [TW-1:0]    run_arr_q;
	logic [TW-1:0]    run_burst_q;
	logic [TW-1:0]    run_left_q;
	logic [TW-1:0]    seg_q;
	logic [TW-1:0]    now_q;

	logic [TW-1:0] now_next;
	logic [TW-1:0] ta;
	logic [TW-1:0] wt;
	logic          preempt;
	logic          finishing;

	logic          emit;
	logic [1:0]    res_kind;
	logic [7:0]    res_job;
	logic [TW-1:0] res_start;
	logic [TW-1:0] res_event;
	logic [TW-1:0] res_ta;
	logic [TW-1:0] res_wt;
	logic          res_last;

	logic          done_q;
	logic [1:0]    kind_q;
	logic [7:0]    out_job_q;
	logic [15:0]   segment_start_q;
	logic [15:0]   event_time_q;
	logic [15:0]   turnaround_q;
	logic [15:0]   waiting_q;
	logic          last_q;

	assign now_next  = now_q + TW'(1);
	assign ta        = now_q - run_arr_q;
	assign wt        = ta - run_burst_q;
	// A job with no time left is never displaced; it completes on the next tick.
	assign preempt   = run_valid_q && (run_left_q != '0) && (pri_q < run_key_q[15:8]);
	assign finishing = run_valid_q && (run_left_q == '0);

	assign op_tick  = (op_q == OP_TICK);
	assign wr_en    = (act == A_ARRIVE) && free_found;
	assign wr_key   = preempt ? run_key_q : {pri_q, id_q};
	assign wr_times = preempt ? {run_arr_q, run_burst_q, run_left_q}
	                          : {now_q, burst_q, burst_q};
	assign clr_en   = (act == A_DISPATCH) && !run_valid_q && best_found;

	always_comb begin
		emit      = 1'b0;
		res_kind  = K_SEGMENT;
		res_job   = run_key_q[7:0];
		res_start = seg_q;
		res_event = now_q;
		res_ta    = '0;
		res_wt    = '0;
		res_last  = 1'b1;
		case (act)
			A_ARRIVE: begin
				if (!free_found) begin
					emit      = 1'b1;
					res_kind  = K_OVERFLOW;
					res_job   = id_q;
					res_start = now_q;
				end else if (preempt && (now_q != seg_q)) begin
					emit = 1'b1;
				end
			end
			A_COMPLETE: begin
				// An idle result follows unless a ready job takes over.
				emit     = finishing;
				res_kind = K_COMPLETE;
				res_ta   = ta;
				res_wt   = wt;
				res_last = best_found;
			end
			A_ADVANCE: begin
				emit      = !run_valid_q;
				res_kind  = K_IDLE;
				res_job   = '0;
				res_start = now_q;
				res_event = now_next;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (act == A_WAIT && start) begin
			op_q    <= operation;
			id_q    <= job_id;
			pri_q   <= job_priority;
			burst_q <= TW'(job_burst);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			run_valid_q <= 1'b0;
			run_key_q   <= '0;
			run_arr_q   <= '0;
			run_burst_q <= '0;
			run_left_q  <= '0;
			seg_q       <= '0;
		end else begin
			case (act)
				A_ARRIVE: begin
					if (free_found && preempt) begin
						run_key_q   <= {pri_q, id_q};
						run_arr_q   <= now_q;
						run_burst_q <= burst_q;
						run_left_q  <= burst_q;
						seg_q       <= now_q;
					end
				end
				A_COMPLETE: begin
					if (finishing) begin
						run_valid_q <= 1'b0;
					end
				end
				A_DISPATCH: begin
					if (!run_valid_q && best_found) begin
						run_valid_q <= 1'b1;
						run_key_q   <= best_key;
						{run_arr_q, run_burst_q, run_left_q} <= best_times;
						seg_q       <= now_q;
					end
				end
				A_ADVANCE: begin
					if (!run_valid_q) begin
						now_q <= now_next;
					end else if (run_left_q != '0) begin
						run_left_q <= run_left_q - TW'(1);
						now_q      <= now_next;
					end
				end
				default: begin
					now_q <= now_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q          <= res_kind;
			out_job_q       <= res_job;
			segment_start_q <= 16'(res_start);
			event_time_q    <= 16'(res_event);
			turnaround_q    <= 16'(res_ta);
			waiting_q       <= 16'(res_wt);
			last_q          <= res_last;
		end
	end

	assign done          = done_q;
	assign kind          = kind_q;
	assign out_job       = out_job_q;
	assign segment_start = segment_start_q;
	assign event_time    = event_time_q;
	assign turnaround    = turnaround_q;
	assign waiting       = waiting_q;
	assign last          = last_q;

endmodule

@@ sv/preemptive_priority_scheduler.sv @@
// Channel   Handshake             Ports
// command   start while !busy     operation, job_id, job_priority, job_burst
// result    done, one cycle       kind, out_job, segment_start, event_time,
//                                 turnaround, waiting, last
//
// An arrival runs the scan, fetch and arrive steps, a tick the scan, fetch, complete,
// dispatch and advance steps, before busy falls; the ready table scan, one key memory
// read per cycle, sets their length. Results leave from a register in the cycle after
// the step that makes them; a tick's two results come from complete and advance.
// Reset needs no clearing pass: the valid flags of the ready table clear at once.
// The receiver cannot stall; done shows every result for exactly one cycle.
//
// Top level of the preemptive priority scheduler. Depends on pps_pkg, pps_sequencer,
// pps_ready_table and pps_job_unit.
`timescale 1ns / 1ps

module preemptive_priority_scheduler import pps_pkg::*; #(
	parameter int READY_DEPTH = PPS_READY_DEPTH,
	parameter int TIME_BITS   = PPS_TIME_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [7:0]  job_id,
	input  logic [7:0]  job_priority,
	input  logic [15:0] job_burst,
	output logic        done,
	output logic [1:0]  kind,
	output logic [7:0]  out_job,
	output logic [15:0] segment_start,
	output logic [15:0] event_time,
	output logic [15:0] turnaround,
	output logic [15:0] waiting,
	output logic        last
);

	act_t                   act;
	seq_flags_t             flags;
	logic                   scan_more;
	logic                   op_tick;
	logic                   wr_en;
	logic [KEY_W-1:0]       wr_key;
	logic [3*TIME_BITS-1:0] wr_times;
	logic                   clr_en;
	logic                   free_found;
	logic                   best_found;
	logic [KEY_W-1:0]       best_key;
	logic [3*TIME_BITS-1:0] best_times;

	assign flags = '{start: start, scan_more: scan_more, tick: op_tick};

	pps_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.act    (act),
		.busy   (busy)
	);

	pps_ready_table #(
		.READY_DEPTH (READY_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.act        (act),
		.wr_en      (wr_en),
		.wr_key     (wr_key),
		.wr_times   (wr_times),
		.clr_en     (clr_en),
		.scan_more  (scan_more),
		.free_found (free_found),
		.best_found (best_found),
		.best_key   (best_key),
		.best_times (best_times)
	);

	pps_job_unit #(
		.TIME_BITS (TIME_BITS)
	) u_job (
		.clk           (clk),
		.arst_n        (arst_n),
		.act           (act),
		.start         (start),
		.operation     (operation),
		.job_id        (job_id),
		.job_priority  (job_priority),
		.job_burst     (job_burst),
		.free_found    (free_found),
		.best_found    (best_found),
		.best_key      (best_key),
		.best_times    (best_times),
		.op_tick       (op_tick),
		.wr_en         (wr_en),
		.wr_key        (wr_key),
		.wr_times      (wr_times),
		.clr_en        (clr_en),
		.done          (done),
		.kind          (kind),
		.out_job       (out_job),
		.segment_start (segment_start),
		.event_time    (event_time),
		.turnaround    (turnaround),
		.waiting       (waiting),
		.last          (last)
	);

	// A result only comes out of work on a command.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result transfer without a command in progress");

	// Only a completion can be followed by a second result.
	a_first_is_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last) |-> (kind == K_COMPLETE))
		else $error("non-final result that is not a completion");

	// The idle result that follows a completion comes from the advance step, after the dispatch step, and ends the item.
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last) |-> ##2 (done && last && kind == K_IDLE))
		else $error("second result of a tick missing");

	// A command transfer always starts the program.
	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command transfer did not start the sequencer");

endmodule
